### sv/gbid_pkg.sv
// Shared types and constants for the GPIO bank with interrupt detection.
// No dependencies; used by gbid_detect, gbid_regs and gpio_bank_with_irq_detect.
package gbid_pkg;

  // Number of implemented pins; bits at and above this are dropped
  localparam int unsigned PINS = 32;
  localparam logic [31:0] PIN_MASK = 32'hFFFF_FFFF >> (32 - PINS);

  // Item kinds
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  // Register addresses
  localparam logic [3:0] REG_OUT      = 4'd0;
  localparam logic [3:0] REG_IN       = 4'd1;
  localparam logic [3:0] REG_STATUS   = 4'd2;
  localparam logic [3:0] REG_CLEAR    = 4'd3;
  localparam logic [3:0] REG_ENABLE   = 4'd4;
  localparam logic [3:0] REG_EDGE     = 4'd5;
  localparam logic [3:0] REG_POLARITY = 4'd6;
  localparam logic [3:0] REG_OE       = 4'd7;
  localparam logic [3:0] REG_OWNER    = 4'd8;

  // One accepted item
  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  reg_addr;
    logic [31:0] write_data;
    logic [31:0] pin_levels;
  } req_t;

  // One result item
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic [31:0] pad_out;
    logic [31:0] pad_enable;
  } rsp_t;

endpackage

### sv/gbid_detect.sv
// Per-pin edge/level interrupt hit detection for one sample tick.
// Depends on gbid_pkg for the pin mask.
module gbid_detect (
  input  logic [31:0] prev,
  input  logic [31:0] levels,
  input  logic [31:0] polarity,
  input  logic [31:0] edge_select,
  output logic [31:0] hit
);

  logic [31:0] rising;
  logic [31:0] falling;
  logic [31:0] edge_hit;
  logic [31:0] level_hit;

  // Transitions against the previous sample, then select by polarity and mode
  always_comb begin
    rising    = ~prev & levels;
    falling   = prev & ~levels;
    edge_hit  = (polarity & rising) | (~polarity & falling);
    level_hit = ~(levels ^ polarity);
    hit       = ((edge_select & edge_hit) | (~edge_select & level_hit))
                & gbid_pkg::PIN_MASK;
  end

endmodule

### sv/gbid_regs.sv
// Register bank: state registers, bus read/write decode and status update.
// Depends on gbid_pkg and gbid_detect; result reflects the state after the item.
module gbid_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  gbid_pkg::req_t req,
  output gbid_pkg::rsp_t rsp
);

  logic [31:0] out_latch, out_latch_next;
  logic [31:0] drive_enable, drive_enable_next;
  logic [31:0] pin_sample, pin_sample_next;
  logic [31:0] irq_status, irq_status_next;
  logic [31:0] irq_enable, irq_enable_next;
  logic [31:0] edge_select, edge_select_next;
  logic [31:0] polarity, polarity_next;
  logic [31:0] owner_bits, owner_bits_next;

  logic [31:0] wdata;
  logic [31:0] levels;
  logic [31:0] hit;
  logic [31:0] rdata;

  assign wdata  = req.write_data & gbid_pkg::PIN_MASK;
  assign levels = req.pin_levels & gbid_pkg::PIN_MASK;

  gbid_detect u_detect (
    .prev        (pin_sample),
    .levels      (levels),
    .polarity    (polarity),
    .edge_select (edge_select),
    .hit         (hit)
  );

  // Next state and read data
  always_comb begin
    out_latch_next    = out_latch;
    drive_enable_next = drive_enable;
    pin_sample_next   = pin_sample;
    irq_status_next   = irq_status;
    irq_enable_next   = irq_enable;
    edge_select_next  = edge_select;
    polarity_next     = polarity;
    owner_bits_next   = owner_bits;
    rdata             = 32'd0;
    unique case (gbid_pkg::mode_t'(req.mode))
      gbid_pkg::MODE_READ: begin
        unique case (req.reg_addr)
          gbid_pkg::REG_OUT:      rdata = out_latch;
          gbid_pkg::REG_IN:       rdata = pin_sample;
          gbid_pkg::REG_STATUS:   rdata = irq_status;
          gbid_pkg::REG_ENABLE:   rdata = irq_enable;
          gbid_pkg::REG_EDGE:     rdata = edge_select;
          gbid_pkg::REG_POLARITY: rdata = polarity;
          gbid_pkg::REG_OE:       rdata = drive_enable;
          gbid_pkg::REG_OWNER:    rdata = owner_bits;
          default:                rdata = 32'd0;
        endcase
      end
      gbid_pkg::MODE_WRITE: begin
        // input sample and status are read-only; clear is write-one-to-clear
        unique case (req.reg_addr)
          gbid_pkg::REG_OUT:      out_latch_next    = wdata;
          gbid_pkg::REG_CLEAR:    irq_status_next   = irq_status & ~wdata;
          gbid_pkg::REG_ENABLE:   irq_enable_next   = wdata;
          gbid_pkg::REG_EDGE:     edge_select_next  = wdata;
          gbid_pkg::REG_POLARITY: polarity_next     = wdata;
          gbid_pkg::REG_OE:       drive_enable_next = wdata;
          gbid_pkg::REG_OWNER:    owner_bits_next   = wdata;
          default:                ;
        endcase
      end
      gbid_pkg::MODE_TICK: begin
        irq_status_next = (irq_status | hit) & gbid_pkg::PIN_MASK;
        pin_sample_next = levels;
      end
      default: ;
    endcase
  end

  // Result fields from the post-item state
  always_comb begin
    rsp.read_data  = rdata;
    rsp.irq        = |(irq_status_next & irq_enable_next);
    rsp.pad_out    = out_latch_next;
    rsp.pad_enable = drive_enable_next;
  end

  // State registers, updated on each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_latch    <= 32'd0;
      drive_enable <= 32'd0;
      pin_sample   <= 32'd0;
      irq_status   <= 32'd0;
      irq_enable   <= 32'd0;
      edge_select  <= 32'd0;
      polarity     <= 32'd0;
      owner_bits   <= 32'd0;
    end else if (take) begin
      out_latch    <= out_latch_next;
      drive_enable <= drive_enable_next;
      pin_sample   <= pin_sample_next;
      irq_status   <= irq_status_next;
      irq_enable   <= irq_enable_next;
      edge_select  <= edge_select_next;
      polarity     <= polarity_next;
      owner_bits   <= owner_bits_next;
    end
  end

endmodule

### sv/gpio_bank_with_irq_detect.sv
// Top level of the GPIO bank with edge/level interrupt detection.
// Depends on gbid_pkg and gbid_regs; stream handshake and result register.
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: mode; tdata: reg_addr, write_data, pin_levels
// m_*       out  m_tvalid/m_tready  tdata: read_data, irq, pad_out, pad_enable
//
// One item per cycle while no held result stalls; each result appears in the cycle after
// its transfer, set by the single result register behind the register-bank update logic.
// rst (synchronous) clears all bank registers to zero and empties the result stage.
// A stalled result holds; a new item is still taken in the cycle the held
// result is taken, so the stream runs at full rate while m_tready stays high.
module gpio_bank_with_irq_detect (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // [3:0] reg_addr, [35:4] write_data, [67:36] pin_levels
  input  logic [1:0]   s_tuser,   // [1:0] mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata    // [31:0] read_data, [32] irq, [64:33] pad_out,
                                  // [96:65] pad_enable
);

  gbid_pkg::req_t req;
  gbid_pkg::rsp_t rsp;
  gbid_pkg::rsp_t rsp_q;
  logic           take;

  // Unpack the input transfer
  always_comb begin
    req.mode       = s_tuser;
    req.reg_addr   = s_tdata[3:0];
    req.write_data = s_tdata[35:4];
    req.pin_levels = s_tdata[67:36];
  end

  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  gbid_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .req  (req),
    .rsp  (rsp)
  );

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (take) begin
      rsp_q <= rsp;
    end
  end

  assign m_tdata = {7'd0, rsp_q.pad_enable, rsp_q.pad_out, rsp_q.irq, rsp_q.read_data};

endmodule

### sim/testbench.sv
// Self-checking testbench for gpio_bank_with_irq_detect: directed and random bus/tick traffic.
// Depends on gbid_pkg (types, register codes, pin mask) and the gpio_bank_with_irq_detect RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int          LIMIT_CYCLES = 200000;
  localparam int          RAND_ITEMS   = 900;
  localparam int          TAIL_ITEMS   = 100;  // no idling on either side for the last items
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam logic [3:0]  REG_NONE_LO  = 4'd9;
  localparam logic [3:0]  REG_NONE_HI  = 4'd15;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;   // [3:0] reg_addr, [35:4] write_data, [67:36] pin_levels
  logic [1:0]   s_tuser = '0;   // [1:0] mode
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;        // [31:0] read_data, [32] irq, [64:33] pad_out, [96:65] pad_enable

  gpio_bank_with_irq_detect u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register bank
  logic [31:0] sh_out, sh_oe, sh_in, sh_status, sh_ien, sh_edge, sh_pol, sh_owner;

  gbid_pkg::req_t pending_items[$];
  gbid_pkg::rsp_t expected_rsp[$];
  gbid_pkg::rsp_t exp_r, got_r;
  gbid_pkg::req_t nxt_item;
  int   mismatches = 0;
  int   cycles = 0;
  int   src_gap = 0;
  int   snk_gap = 0;
  int   idle_pct;
  logic [31:0] gen_levels = '0;

  initial begin
    sh_out = '0; sh_oe = '0; sh_in = '0; sh_status = '0;
    sh_ien = '0; sh_edge = '0; sh_pol = '0; sh_owner = '0;
  end

  // Apply one transfer to the shadow bank and form the response it should produce
  task automatic gpio_predict(input logic [1:0] mode, input logic [3:0] addr,
                              input logic [31:0] wdata, input logic [31:0] levels,
                              output gbid_pkg::rsp_t rsp);
    logic [31:0] rd, d, lv, rising, falling, edge_hit, level_hit, hit;
    d  = wdata & gbid_pkg::PIN_MASK;
    lv = levels & gbid_pkg::PIN_MASK;
    rd = '0;
    case (mode)
      gbid_pkg::MODE_READ: begin
        case (addr)
          gbid_pkg::REG_OUT:      rd = sh_out;
          gbid_pkg::REG_IN:       rd = sh_in;
          gbid_pkg::REG_STATUS:   rd = sh_status;
          gbid_pkg::REG_ENABLE:   rd = sh_ien;
          gbid_pkg::REG_EDGE:     rd = sh_edge;
          gbid_pkg::REG_POLARITY: rd = sh_pol;
          gbid_pkg::REG_OE:       rd = sh_oe;
          gbid_pkg::REG_OWNER:    rd = sh_owner;
          default:                rd = '0;
        endcase
      end
      gbid_pkg::MODE_WRITE: begin
        case (addr)
          gbid_pkg::REG_OUT:      sh_out = d;
          gbid_pkg::REG_CLEAR:    sh_status = sh_status & ~d;
          gbid_pkg::REG_ENABLE:   sh_ien = d;
          gbid_pkg::REG_EDGE:     sh_edge = d;
          gbid_pkg::REG_POLARITY: sh_pol = d;
          gbid_pkg::REG_OE:       sh_oe = d;
          gbid_pkg::REG_OWNER:    sh_owner = d;
          default:                ;
        endcase
      end
      gbid_pkg::MODE_TICK: begin
        // edge pins compare against the previous sample, level pins against polarity
        rising    = ~sh_in & lv;
        falling   = sh_in & ~lv;
        edge_hit  = (sh_pol & rising) | (~sh_pol & falling);
        level_hit = ~(lv ^ sh_pol);
        hit       = (sh_edge & edge_hit) | (~sh_edge & level_hit);
        sh_status = (sh_status | hit) & gbid_pkg::PIN_MASK;
        sh_in     = lv;
      end
      default: ;
    endcase
    rsp.read_data  = rd;
    rsp.irq        = |(sh_status & sh_ien);
    rsp.pad_out    = sh_out;
    rsp.pad_enable = sh_oe;
  endtask

  task automatic queue_item(input logic [1:0] mode, input logic [3:0] addr,
                            input logic [31:0] wdata, input logic [31:0] levels);
    gbid_pkg::req_t r;
    r.mode       = mode;
    r.reg_addr   = addr;
    r.write_data = wdata;
    r.pin_levels = levels;
    pending_items.push_back(r);
  endtask

  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h0000_0000;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return $urandom & $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_item();
    int          sel;
    logic [3:0]  addr;
    logic [31:0] flips;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 6)
      addr = 4'($urandom_range(REG_NONE_LO, REG_NONE_HI));
    else if ($urandom_range(0, 3) == 0)
      addr = gbid_pkg::REG_CLEAR;
    else
      addr = 4'($urandom_range(gbid_pkg::REG_OUT, gbid_pkg::REG_OWNER));
    if (sel < 4) begin
      queue_item(MODE_UNUSED, addr, $urandom, $urandom);
    end else if (sel < 38) begin
      // mostly small moves from the last levels so edges are sparse, sometimes a jump
      case ($urandom_range(0, 5))
        0:       gen_levels = pick_word();
        1:       gen_levels = ~gen_levels;
        default: begin
          flips = $urandom & $urandom & $urandom;
          gen_levels = gen_levels ^ flips;
        end
      endcase
      queue_item(gbid_pkg::MODE_TICK, addr, $urandom, gen_levels);
    end else if (sel < 72) begin
      queue_item(gbid_pkg::MODE_WRITE, addr, pick_word(), $urandom);
    end else begin
      queue_item(gbid_pkg::MODE_READ, addr, $urandom, $urandom);
    end
  endtask

  // Stimulus, reset and end of run
  initial begin
    // first tick after reset with rising-edge pins set
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_EDGE,     32'hFFFF_FFFF, 32'h0);
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_POLARITY, 32'hFFFF_FFFF, 32'h0);
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_ENABLE,   32'hFFFF_FFFF, 32'h0);
    queue_item(gbid_pkg::MODE_TICK,  gbid_pkg::REG_OUT,      32'h0,         32'hFFFF_FFFF);
    queue_item(gbid_pkg::MODE_READ,  gbid_pkg::REG_STATUS,   32'h0,         32'h0);
    // read-only registers ignore writes
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_STATUS,   32'h0,         32'h0);
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_IN,       32'h0,         32'h0);
    queue_item(gbid_pkg::MODE_READ,  gbid_pkg::REG_IN,       32'h0,         32'h0);
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_CLEAR,    32'hFFFF_FFFF, 32'h0);
    queue_item(gbid_pkg::MODE_READ,  gbid_pkg::REG_CLEAR,    32'hFFFF_FFFF, 32'h0);
    // falling edges, then partial clear
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_POLARITY, 32'h0,         32'h0);
    queue_item(gbid_pkg::MODE_TICK,  gbid_pkg::REG_OUT,      32'h0,         32'h0);
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_CLEAR,    32'h5555_5555, 32'h0);
    queue_item(gbid_pkg::MODE_READ,  gbid_pkg::REG_STATUS,   32'h0,         32'h0);
    // level pins, active low
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_EDGE,     32'h0,         32'h0);
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_CLEAR,    32'hFFFF_FFFF, 32'h0);
    queue_item(gbid_pkg::MODE_TICK,  gbid_pkg::REG_OUT,      32'h0,         32'hFFFF_FFFF);
    queue_item(gbid_pkg::MODE_TICK,  gbid_pkg::REG_OUT,      32'h0,         32'h0);
    // pad outputs and owner at the extremes
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_OUT,      32'hFFFF_FFFF, 32'h0);
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_OE,       32'hFFFF_FFFF, 32'h0);
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_OWNER,    32'hFFFF_FFFF, 32'h0);
    queue_item(gbid_pkg::MODE_READ,  gbid_pkg::REG_OWNER,    32'h0,         32'h0);
    // unused address and unused mode
    queue_item(gbid_pkg::MODE_WRITE, REG_NONE_HI,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(gbid_pkg::MODE_READ,  REG_NONE_HI,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(MODE_UNUSED, gbid_pkg::REG_OUT,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_OUT,      32'h0,         32'h0);
    queue_item(gbid_pkg::MODE_WRITE, gbid_pkg::REG_OE,       32'h0,         32'h0);
    repeat (RAND_ITEMS) queue_random_item();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("gpio_bank_with_irq_detect regression: pass");
    end else begin
      $display("gpio_bank_with_irq_detect regression: fail");
    end
    $finish;
  end

  // Cycle limit; also picks the idling density for the current stretch
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("gpio_bank_with_irq_detect regression: fail");
      $finish;
    end
  end

  always_comb begin
    case ((cycles / 256) % 3)
      0:       idle_pct = 0;
      1:       idle_pct = 10;
      default: idle_pct = 35;
    endcase
  end

  // Driver: predict on each accepted transfer, then present the next item
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        gpio_predict(s_tuser, s_tdata[3:0], s_tdata[35:4], s_tdata[67:36], exp_r);
        expected_rsp.push_back(exp_r);
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nxt_item = pending_items.pop_front();
          s_tdata  <= {4'b0, nxt_item.pin_levels, nxt_item.write_data, nxt_item.reg_addr};
          s_tuser  <= nxt_item.mode;
          s_tvalid <= 1'b1;
          if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 99) < idle_pct)
            src_gap = $urandom_range(1, 8);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Monitor: compare each result transfer with the oldest prediction; random backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
          mismatches++;
        end else begin
          got_r = expected_rsp.pop_front();
          check_field("read_data",  got_r.read_data,  m_tdata[31:0]);
          check_field("irq",        {31'b0, got_r.irq}, {31'b0, m_tdata[32]});
          check_field("pad_out",    got_r.pad_out,    m_tdata[64:33]);
          check_field("pad_enable", got_r.pad_enable, m_tdata[96:65]);
        end
      end
      if (snk_gap > 0) begin
        snk_gap = snk_gap - 1;
        m_tready <= 1'b0;
      end else if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 99) < idle_pct) begin
        snk_gap = $urandom_range(1, 8) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

endmodule
